>>> hdl/lrgd_pkg.sv
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared types, constants and fixed-point helpers of the gradient-descent
// trainer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrgd_pkg;

  localparam logic [1:0] CFG_STEP_GAIN       = 2'd0;
  localparam logic [1:0] CFG_ITERATION_COUNT = 2'd1;
  localparam logic [1:0] CFG_FEATURE_COUNT   = 2'd2;

  localparam logic [15:0] RST_STEP_GAIN       = 16'd655;
  localparam logic [15:0] RST_ITERATION_COUNT = 16'd1000;
  localparam logic [3:0]  RST_FEATURE_COUNT   = 4'd8;

  localparam logic [46:0] AVG_LIMIT = {47{1'b1}};

  typedef struct packed {
    logic clr;
    logic rd;
    logic pmul;
    logic pacc;
    logic err;
    logic g0;
    logic gmul;
    logic gacc;
    logic div_start;
    logic umul;
    logic usub;
    logic out_load;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  function automatic logic signed [47:0] qmul_trunc(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    return adj[63:16];
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/lrgd_div.sv
// ----------------------------------------------------------------------------
// lrgd_div
// Radix-2 restoring divider of a signed 64-bit sum by the sample count, with
// the quotient magnitude clamped to 47 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lrgd_div #(
  parameter int CW = 9
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [63:0]  dividend,
  input  wire logic [CW-1:0]       divisor,
  output logic                     done,
  output logic [46:0]              q_mag,
  output logic                     q_neg
);

  logic [63:0] quo;
  logic [CW-1:0] rem;
  logic [6:0] cnt;
  logic busy;
  logic [CW:0] trial;

  assign trial = {rem, quo[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[63] ? 64'(-dividend) : dividend;
      q_neg <= dividend[63];
      rem   <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= CW'(trial - {1'b0, divisor});
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial[CW-1:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign q_mag = (quo > {17'd0, lrgd_pkg::AVG_LIMIT}) ? lrgd_pkg::AVG_LIMIT : quo[46:0];

endmodule

`default_nettype wire

>>> hdl/lrgd_dp.sv
// ----------------------------------------------------------------------------
// lrgd_dp
// Datapath: sample memories, coefficient and gradient registers, the shared
// multiplier, the divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrgd_dp #(
  parameter int MAX_FEATURES = 8,
  parameter int MAX_SAMPLES  = 256,
  parameter int SW  = 8,
  parameter int CW  = 9,
  parameter int JW  = 4,
  parameter int FIW = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lrgd_pkg::cmd_t                    cmd,
  output lrgd_pkg::sts_t                         sts,
  input  wire logic                              wr_en,
  input  wire logic [SW-1:0]                     wr_addr,
  input  wire logic [MAX_FEATURES-1:0][31:0]     wr_row,
  input  wire logic [31:0]                       wr_target,
  input  wire logic [SW-1:0]                     rd_addr,
  input  wire logic [JW-1:0]                     sel,
  input  wire logic [FIW-1:0]                    fsel,
  input  wire logic [CW-1:0]                     count,
  input  wire logic [15:0]                       step_gain,
  output logic [3:0]                             coef_index,
  output logic signed [31:0]                     coef_value,
  output logic                                   last_coef
);

  localparam int NC = MAX_FEATURES + 1;

  logic [MAX_FEATURES-1:0][31:0] feat_mem [MAX_SAMPLES];
  logic [31:0] tgt_mem [MAX_SAMPLES];
  logic [MAX_FEATURES-1:0][31:0] row_q;
  logic signed [31:0] tgt_q;
  logic signed [31:0] coef [NC];
  logic signed [63:0] gsum [NC];
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [31:0] err_q;
  logic [46:0] step_mag;
  logic step_neg;
  logic signed [31:0] coef_rd;
  logic signed [63:0] gsum_rd;
  logic signed [31:0] feat_sel;
  logic signed [31:0] mul_a;
  logic signed [31:0] pred;
  logic signed [32:0] diff;
  logic signed [48:0] step_s;
  logic signed [48:0] upd;
  logic [62:0] step_full;
  logic div_done;
  logic [46:0] q_mag;
  logic q_neg;

  assign coef_rd  = coef[sel];
  assign gsum_rd  = gsum[sel];
  assign feat_sel = row_q[fsel];
  assign mul_a    = cmd.pmul ? coef_rd : err_q;
  assign pred     = lrgd_pkg::sat32(acc);
  assign diff     = {pred[31], pred} - {tgt_q[31], tgt_q};
  assign step_s   = step_neg ? -{2'b00, step_mag} : {2'b00, step_mag};
  assign upd      = {{17{coef_rd[31]}}, coef_rd} - step_s;
  assign step_full = q_mag * step_gain;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      feat_mem[wr_addr] <= wr_row;
      tgt_mem[wr_addr]  <= wr_target;
    end
    if (cmd.rd) begin
      row_q <= feat_mem[rd_addr];
      tgt_q <= tgt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pmul || cmd.gmul) begin
      prod <= mul_a * feat_sel;
    end
    if (cmd.rd) begin
      acc <= {{32{coef_rd[31]}}, coef_rd};
    end else if (cmd.pacc) begin
      acc <= acc + {{16{1'b0}}, 48'd0} + 64'(lrgd_pkg::qmul_trunc(prod));
    end
    if (cmd.err) begin
      err_q <= lrgd_pkg::sat32({{31{diff[32]}}, diff});
    end
    if (cmd.umul) begin
      step_mag <= step_full[62:16];
      step_neg <= q_neg;
    end
    if (cmd.out_load) begin
      coef_index <= 4'(sel);
      coef_value <= coef_rd;
      last_coef  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NC; i++) begin
        coef[i] <= '0;
      end
    end else if (cmd.usub) begin
      coef[sel] <= lrgd_pkg::sat32({{15{upd[48]}}, upd});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      for (int i = 0; i < NC; i++) begin
        gsum[i] <= '0;
      end
    end else if (cmd.g0) begin
      gsum[0] <= lrgd_pkg::sat_add64(gsum[0], {{32{err_q[31]}}, err_q});
    end else if (cmd.gacc) begin
      gsum[sel] <= lrgd_pkg::sat_add64(gsum_rd, 64'(lrgd_pkg::qmul_trunc(prod)));
    end
  end

  lrgd_div #(
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (gsum_rd),
    .divisor  (count),
    .done     (div_done),
    .q_mag    (q_mag),
    .q_neg    (q_neg)
  );

  assign sts.div_done = div_done;

endmodule

`default_nettype wire

>>> hdl/lrgd_ctrl.sv
// ----------------------------------------------------------------------------
// lrgd_ctrl
// Controller: sample loading, the training sequence and coefficient output.
// ----------------------------------------------------------------------------
`default_nettype none

module lrgd_ctrl #(
  parameter int MAX_FEATURES = 8,
  parameter int MAX_SAMPLES  = 256,
  parameter int SW  = 8,
  parameter int CW  = 9,
  parameter int JW  = 4,
  parameter int FIW = 3
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            last_sample,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire logic [15:0]     iteration_count,
  input  wire logic [3:0]      feature_count,
  input  wire lrgd_pkg::sts_t  sts,
  output lrgd_pkg::cmd_t       cmd,
  output logic                 wr_en,
  output logic [SW-1:0]        wr_addr,
  output logic [SW-1:0]        rd_addr,
  output logic [JW-1:0]        sel,
  output logic [FIW-1:0]       fsel,
  output logic [CW-1:0]        count
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLR   = 14'b00000000000010,
    S_RD    = 14'b00000000000100,
    S_PMUL  = 14'b00000000001000,
    S_PACC  = 14'b00000000010000,
    S_ERR   = 14'b00000000100000,
    S_G0    = 14'b00000001000000,
    S_GMUL  = 14'b00000010000000,
    S_GACC  = 14'b00000100000000,
    S_UDIV  = 14'b00001000000000,
    S_UWAIT = 14'b00010000000000,
    S_UMUL  = 14'b00100000000000,
    S_USUB  = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic [SW-1:0] smp, smp_next;
  logic [JW-1:0] j, j_next;
  logic [15:0] iter, iter_next;
  logic [CW-1:0] count_next;
  logic out_valid_next;
  logic [JW-1:0] nf;
  logic accept;
  logic out_free;

  always_comb begin
    if (feature_count == 4'd0) begin
      nf = JW'(1);
    end else if (32'(feature_count) > MAX_FEATURES) begin
      nf = JW'(MAX_FEATURES);
    end else begin
      nf = JW'(feature_count);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign wr_en    = accept && (32'(count) < MAX_SAMPLES);
  assign wr_addr  = count[SW-1:0];
  assign rd_addr  = smp;
  assign fsel     = j[FIW-1:0];

  always_comb begin
    state_next     = state;
    smp_next       = smp;
    j_next         = j;
    iter_next      = iter;
    count_next     = count;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    sel            = j;
    unique case (state)
      S_IDLE: begin
        if (wr_en) begin
          count_next = count + CW'(1);
        end
        if (accept && last_sample) begin
          j_next    = '0;
          iter_next = '0;
          if (iteration_count == 16'd0) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.clr    = 1'b1;
        smp_next   = '0;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        sel        = '0;
        j_next     = '0;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.pmul   = 1'b1;
        sel        = j + JW'(1);
        state_next = S_PACC;
      end
      S_PACC: begin
        cmd.pacc = 1'b1;
        if (j == nf - JW'(1)) begin
          state_next = S_ERR;
        end else begin
          j_next     = j + JW'(1);
          state_next = S_PMUL;
        end
      end
      S_ERR: begin
        cmd.err    = 1'b1;
        state_next = S_G0;
      end
      S_G0: begin
        cmd.g0     = 1'b1;
        j_next     = '0;
        state_next = S_GMUL;
      end
      S_GMUL: begin
        cmd.gmul   = 1'b1;
        state_next = S_GACC;
      end
      S_GACC: begin
        cmd.gacc = 1'b1;
        sel      = j + JW'(1);
        if (j == nf - JW'(1)) begin
          j_next = '0;
          if (CW'(smp) == count - CW'(1)) begin
            state_next = S_UDIV;
          end else begin
            smp_next   = smp + SW'(1);
            state_next = S_RD;
          end
        end else begin
          j_next     = j + JW'(1);
          state_next = S_GMUL;
        end
      end
      S_UDIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_UWAIT;
      end
      S_UWAIT: begin
        if (sts.div_done) begin
          state_next = S_UMUL;
        end
      end
      S_UMUL: begin
        cmd.umul   = 1'b1;
        state_next = S_USUB;
      end
      S_USUB: begin
        cmd.usub = 1'b1;
        if (j == nf) begin
          j_next = '0;
          if (iter == iteration_count - 16'd1) begin
            iter_next  = '0;
            state_next = S_EMIT;
          end else begin
            iter_next  = iter + 16'd1;
            state_next = S_CLR;
          end
        end else begin
          j_next     = j + JW'(1);
          state_next = S_UDIV;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.last       = (j == nf);
          out_valid_next = 1'b1;
          if (j == nf) begin
            j_next     = '0;
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            j_next = j + JW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      smp       <= '0;
      j         <= '0;
      iter      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      smp       <= smp_next;
      j         <= j_next;
      iter      <= iter_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  a_div_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_UWAIT && sts.div_done) |=> (state == S_UMUL))
    else $error("divider completion did not advance the update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_SAMPLES)
    else $error("sample count beyond store depth");

  a_feat_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_GACC || state == S_PACC) |-> (j < nf))
    else $error("feature index out of range");

endmodule

`default_nettype wire

>>> hdl/linear_regression_gd_trainer.sv
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer
// Batch gradient-descent trainer for linear regression in Q16.16.
// ----------------------------------------------------------------------------
// Samples go into the sample memory one beat per cycle while it has room;
// the last_sample beat starts training, or the output if the iteration count
// is zero, and no input is taken until the last coefficient beat is loaded.
// Each iteration clears the gradient sums, passes over every stored sample
// (one shared 32x32 multiplier used for the prediction and again for the
// gradients) and updates the coefficients, dominated by the 64-step divider
// by the sample count. The F+1 coefficients (F the active feature count) go
// out one beat per cycle unless out_stall holds them, intercept first.
`default_nettype none

module linear_regression_gd_trainer #(
  parameter int MAX_FEATURES = 8,
  parameter int MAX_SAMPLES  = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] feature_0,
  input  wire logic signed [31:0] feature_1,
  input  wire logic signed [31:0] feature_2,
  input  wire logic signed [31:0] feature_3,
  input  wire logic signed [31:0] feature_4,
  input  wire logic signed [31:0] feature_5,
  input  wire logic signed [31:0] feature_6,
  input  wire logic signed [31:0] feature_7,
  input  wire logic signed [31:0] target_value,
  input  wire logic               last_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              coef_index,
  output logic signed [31:0]      coef_value,
  output logic                    last_coef
);

  localparam int SW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int JW  = $clog2(MAX_FEATURES + 1);
  localparam int FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  logic [15:0] step_gain;
  logic [15:0] iteration_count;
  logic [3:0]  feature_count;
  logic [7:0][31:0] feat_all;
  lrgd_pkg::cmd_t cmd;
  lrgd_pkg::sts_t sts;
  logic wr_en;
  logic [SW-1:0] wr_addr;
  logic [SW-1:0] rd_addr;
  logic [JW-1:0] sel;
  logic [FIW-1:0] fsel;
  logic [CW-1:0] count;

  assign cfg_ready = 1'b1;
  assign feat_all  = {feature_7, feature_6, feature_5, feature_4,
                      feature_3, feature_2, feature_1, feature_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain       <= lrgd_pkg::RST_STEP_GAIN;
      iteration_count <= lrgd_pkg::RST_ITERATION_COUNT;
      feature_count   <= lrgd_pkg::RST_FEATURE_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lrgd_pkg::CFG_STEP_GAIN:       step_gain       <= cfg_data;
        lrgd_pkg::CFG_ITERATION_COUNT: iteration_count <= cfg_data;
        lrgd_pkg::CFG_FEATURE_COUNT:   feature_count   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  lrgd_ctrl #(
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_SAMPLES (MAX_SAMPLES),
    .SW(SW), .CW(CW), .JW(JW), .FIW(FIW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .last_sample     (last_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .iteration_count (iteration_count),
    .feature_count   (feature_count),
    .sts             (sts),
    .cmd             (cmd),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .sel             (sel),
    .fsel            (fsel),
    .count           (count)
  );

  lrgd_dp #(
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_SAMPLES (MAX_SAMPLES),
    .SW(SW), .CW(CW), .JW(JW), .FIW(FIW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_row        (feat_all[MAX_FEATURES-1:0]),
    .wr_target     (target_value),
    .rd_addr       (rd_addr),
    .sel           (sel),
    .fsel          (fsel),
    .count         (count),
    .step_gain     (step_gain),
    .coef_index    (coef_index),
    .coef_value    (coef_value),
    .last_coef     (last_coef)
  );

endmodule

`default_nettype wire
